@@ design/penalty_contact_node_kernel_top_macros.svh @@
// Assertion macros for the penalty contact node kernel.
// Taken in by the top level, which checks its own pipeline; no other dependency.
`ifndef PENALTY_CONTACT_NODE_KERNEL_TOP_MACROS_SVH
`define PENALTY_CONTACT_NODE_KERNEL_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define PCNK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PCNK_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PCNK_ASSERT(label, prop, msg)
`define PCNK_ASSERT_NORST(label, prop, msg)
`endif
`endif

@@ design/pcnk_pkg.sv @@
// Shared types, constants and rounding helper of the penalty contact node kernel.
// No dependencies.
package pcnk_pkg;

    localparam int DIMENSION   = 3;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int SHIFT_FORCE = 62;
    localparam int SHIFT_STIFF = 76;

    typedef enum logic [1:0] {
        REG_PENALTY_COEFF = 2'd0,
        REG_NODAL_AREA    = 2'd1,
        REG_CONTACT_MODE  = 2'd2,
        REG_REACTION_MODE = 2'd3
    } reg_index_t;

    // Data that rides alongside the square root and division pipelines
    typedef struct packed {
        logic [2:0][31:0] disp;
        logic [2:0][31:0] mag;
        logic [2:0]       pos;
    } side_t;

    // Round a product to nearest, ties away from zero, apply sign, saturate to 48 bits
    function automatic logic [47:0] round_sat(input logic [127:0] prod, input logic neg,
                                              input int unsigned shift);
        logic [127:0] sum;
        logic [127:0] mag;
        logic [47:0]  limit;
        logic [47:0]  m;
        sum   = prod + (128'd1 << (shift - 1));
        mag   = sum >> shift;
        limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        m     = (mag > {80'd0, limit}) ? limit : mag[47:0];
        return neg ? 48'(-m) : m;
    endfunction

endpackage

@@ design/pcnk_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, for the normal length.
// Depends on pcnk_pkg.
module pcnk_sqrt import pcnk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_vld,
    input  logic [63:0] in_sum,
    input  side_t       in_side,
    output logic        out_vld,
    output logic [31:0] out_root,
    output side_t       out_side
);

    logic        vld_reg  [SQRT_STAGES];
    logic [63:0] n_reg    [SQRT_STAGES];
    logic [33:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];
    side_t       side_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic        v_in;
        logic [63:0] n_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        side_t       side_in;
        logic [35:0] cur;
        logic [35:0] trial;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign n_in    = in_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two bits and try root*4+1
        assign cur   = {rem_in, n_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_comb begin
            if (cur >= trial) begin
                rem_next  = 34'(cur - trial);
                root_next = {root_in[30:0], 1'b1};
            end else begin
                rem_next  = cur[33:0];
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= {n_in[61:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STAGES-1];
    assign out_root = root_reg[SQRT_STAGES-1];
    assign out_side = side_reg[SQRT_STAGES-1];

endmodule

@@ design/pcnk_div.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage, for the unit normal.
// Depends on pcnk_pkg.
module pcnk_div import pcnk_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [2:0][61:0] in_num,
    input  logic [31:0]      in_root,
    input  side_t            in_side,
    output logic             out_vld,
    output logic [2:0][30:0] out_quot,
    output logic [31:0]      out_root,
    output side_t            out_side
);

    logic             vld_reg  [DIV_STAGES];
    logic [2:0][31:0] rem_reg  [DIV_STAGES];
    logic [2:0][30:0] lo_reg   [DIV_STAGES];
    logic [2:0][30:0] q_reg    [DIV_STAGES];
    logic [31:0]      root_reg [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic             v_in;
        logic [2:0][31:0] rem_in;
        logic [2:0][30:0] lo_in;
        logic [2:0][30:0] q_in;
        logic [31:0]      root_in;
        side_t            side_in;
        logic [2:0][31:0] rem_next;
        logic [2:0][30:0] lo_next;
        logic [2:0][30:0] q_next;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign root_in = in_root;
            assign side_in = in_side;
            assign q_in    = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                // quotient fits 31 bits, so the top part is already below the divisor
                assign rem_in[l] = {1'b0, in_num[l][61:31]};
                assign lo_in[l]  = in_num[l][30:0];
            end
        end else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign lo_in   = lo_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            logic [32:0] cur;
            for (int l = 0; l < 3; l++) begin
                cur        = {rem_in[l], lo_in[l][30]};
                lo_next[l] = {lo_in[l][29:0], 1'b0};
                if (cur >= {1'b0, root_in}) begin
                    rem_next[l] = 32'(cur - {1'b0, root_in});
                    q_next[l]   = {q_in[l][29:0], 1'b1};
                end else begin
                    rem_next[l] = cur[31:0];
                    q_next[l]   = {q_in[l][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= lo_next;
                q_reg[k]    <= q_next;
                root_reg[k] <= root_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_quot = q_reg[DIV_STAGES-1];
    assign out_root = root_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

@@ design/pcnk_mul64.sv @@
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Depends on pcnk_pkg.
module pcnk_mul64 import pcnk_pkg::*; (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod
);

    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            pp01_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            pp10_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            pp11_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            prod_reg <= {pp11_reg, 64'd0} + {32'd0, pp01_reg, 32'd0}
                      + {32'd0, pp10_reg, 32'd0} + {64'd0, pp00_reg};
        end
    end

    assign prod = prod_reg;

endmodule

@@ design/penalty_contact_node_kernel_top.sv @@
// Top level of the penalty contact node kernel: stream ports, APB registers, pipeline.
// Depends on pcnk_pkg, pcnk_sqrt, pcnk_div, pcnk_mul64 and the assertion macro header.
//
//  Port group | Direction | Beat contents
//  s_*        | in        | tdata: disp_x, disp_y, disp_z, norm_x, norm_y, norm_z
//  m_*        | out       | tdata: penetration, force x/y/z, six stiffness entries; tuser: applied
//  APB        | in/out    | penalty_coeff, nodal_area, contact_mode, reaction_mode
//
// One beat enters per cycle while the output is not stalled; a result passes through the
// 32-stage square root, the 31-stage divider and 12 stages around them. Reset is synchronous and
// clears the valid bits and the configuration registers. A stalled output holds the
// whole pipeline, so nothing is lost or repeated.
module penalty_contact_node_kernel_top import pcnk_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // disp_x, disp_y, disp_z, norm_x, norm_y, norm_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [479:0] m_tdata,   // penetration, force_x, force_y, force_z, stiff_xx,
                                    // stiff_xy, stiff_xz, stiff_yy, stiff_yz, stiff_zz
    output logic [0:0]   m_tuser,   // applied
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "penalty_contact_node_kernel_top_macros.svh"

    localparam int PAIR_ROW [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_COL [6] = '{0, 1, 2, 1, 2, 2};

    // configuration
    logic [31:0] penalty_coeff_reg, nodal_area_reg;
    logic        contact_mode_reg, reaction_mode_reg;
    logic [63:0] ka_reg;
    reg_index_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            penalty_coeff_reg <= '0;
            nodal_area_reg    <= '0;
            contact_mode_reg  <= 1'b0;
            reaction_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_PENALTY_COEFF: penalty_coeff_reg <= pwdata;
                REG_NODAL_AREA:    nodal_area_reg    <= pwdata;
                REG_CONTACT_MODE:  contact_mode_reg  <= pwdata[0];
                REG_REACTION_MODE: reaction_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PENALTY_COEFF: prdata = penalty_coeff_reg;
            REG_NODAL_AREA:    prdata = nodal_area_reg;
            REG_CONTACT_MODE:  prdata = {31'd0, contact_mode_reg};
            REG_REACTION_MODE: prdata = {31'd0, reaction_mode_reg};
            default:           prdata = '0;
        endcase
    end

    // the user must change registers only while idle (not enforced), so k*A settles before use
    always_ff @(posedge aclk) begin
        ka_reg <= 64'(penalty_coeff_reg) * 64'(nodal_area_reg);
    end

    // pipeline advance
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    // valid bits
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg;
    logic sq_vld, dv_vld;

    // stage a: unpack, take magnitudes
    side_t a_side_reg, a_side_next;
    always_comb begin
        logic signed [31:0] raw;
        logic               used;
        for (int i = 0; i < 3; i++) begin
            used = (i < 2) || (DIMENSION == 3);
            raw  = $signed(s_tdata[96 + 32*i +: 32]);
            a_side_next.disp[i] = used ? s_tdata[32*i +: 32] : 32'd0;
            a_side_next.mag[i]  = !used ? 32'd0 : (raw[31] ? 32'(-raw) : 32'(raw));
            a_side_next.pos[i]  = used && !raw[31] && (raw != 32'sd0);
        end
    end

    // stage b: squares; stage c: sum of squares
    logic [2:0][63:0] b_sq_reg;
    side_t            b_side_reg, c_side_reg;
    logic [63:0]      c_sum_reg;

    // square root output and stage d: dividends
    logic [31:0]      sq_root;
    side_t            sq_side;
    logic [2:0][61:0] d_num_reg;
    logic [31:0]      d_root_reg;
    side_t            d_side_reg;

    // divider output
    logic [2:0][30:0] dv_quot;
    logic [31:0]      dv_root;
    side_t            dv_side;

    // stages e..h: unit normal, dot product, penetration
    logic [2:0][30:0]        e_um_reg, f_um_reg, g_um_reg, h_um_reg;
    logic [2:0]              e_uneg_reg, f_uneg_reg, g_uneg_reg, h_uneg_reg;
    logic [2:0][31:0]        e_disp_reg;
    logic [2:0][63:0]        f_dp_reg;
    logic signed [63:0]      g_acc_reg;
    logic [33:0]             h_pmag_reg;
    logic                    h_pneg_reg;
    logic                    h_applied_reg;
    logic [47:0]             h_pen_reg;

    // stage i: multiplicands for the k*A products
    logic [8:0][63:0] i_b_reg;
    logic [8:0]       i_neg_reg, j_neg_reg, k_neg_reg;
    logic             i_applied_reg, j_applied_reg, k_applied_reg;
    logic [47:0]      i_pen_reg, j_pen_reg, k_pen_reg;
    logic [8:0][127:0] prod;

    // output register
    logic [479:0] m_tdata_reg;
    logic         m_applied_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            d_vld_reg    <= 1'b0;
            e_vld_reg    <= 1'b0;
            f_vld_reg    <= 1'b0;
            g_vld_reg    <= 1'b0;
            h_vld_reg    <= 1'b0;
            i_vld_reg    <= 1'b0;
            j_vld_reg    <= 1'b0;
            k_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg    <= s_tvalid;
            b_vld_reg    <= a_vld_reg;
            c_vld_reg    <= b_vld_reg;
            d_vld_reg    <= sq_vld;
            e_vld_reg    <= dv_vld;
            f_vld_reg    <= e_vld_reg;
            g_vld_reg    <= f_vld_reg;
            h_vld_reg    <= g_vld_reg;
            i_vld_reg    <= h_vld_reg;
            j_vld_reg    <= i_vld_reg;
            k_vld_reg    <= j_vld_reg;
            m_tvalid_reg <= k_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            for (int i = 0; i < 3; i++) begin
                b_sq_reg[i] <= 64'(a_side_reg.mag[i]) * 64'(a_side_reg.mag[i]);
            end
            b_side_reg <= a_side_reg;
            c_sum_reg  <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_side_reg <= b_side_reg;
        end
    end

    pcnk_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (c_vld_reg),
        .in_sum   (c_sum_reg),
        .in_side  (c_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // |raw| * 2^30 plus half the divisor rounds the quotient
                d_num_reg[i] <= {sq_side.mag[i], 30'd0} + {31'd0, sq_root[31:1]};
            end
            d_root_reg <= sq_root;
            d_side_reg <= sq_side;
        end
    end

    pcnk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (d_vld_reg),
        .in_num   (d_num_reg),
        .in_root  (d_root_reg),
        .in_side  (d_side_reg),
        .out_vld  (dv_vld),
        .out_quot (dv_quot),
        .out_root (dv_root),
        .out_side (dv_side)
    );

    // stage h combinational: round the dot product
    logic [63:0] h_amag;
    logic [63:0] h_rnd;
    logic [33:0] h_pmag_next;
    logic        h_pneg_next;
    assign h_amag      = g_acc_reg[63] ? 64'(-g_acc_reg) : 64'(g_acc_reg);
    assign h_rnd       = h_amag + 64'(1 << 29);
    assign h_pmag_next = h_rnd[63:30];
    assign h_pneg_next = g_acc_reg[63] && (h_pmag_next != 34'd0);

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage e: zero normal gives a zero unit vector
            for (int i = 0; i < 3; i++) begin
                e_um_reg[i]   <= (dv_root != 32'd0) ? dv_quot[i] : 31'd0;
                e_uneg_reg[i] <= dv_side.pos[i] && (dv_root != 32'd0)
                                 && (dv_quot[i] != 31'd0);
            end
            e_disp_reg <= dv_side.disp;

            // stage f: per-axis products of displacement and unit normal
            for (int i = 0; i < 3; i++) begin
                f_dp_reg[i] <= 64'($signed(e_disp_reg[i]))
                             * (e_uneg_reg[i] ? -64'({33'd0, e_um_reg[i]})
                                              : 64'({33'd0, e_um_reg[i]}));
            end
            f_um_reg   <= e_um_reg;
            f_uneg_reg <= e_uneg_reg;

            // stage g: dot product
            g_acc_reg  <= $signed(f_dp_reg[0]) + $signed(f_dp_reg[1]) + $signed(f_dp_reg[2]);
            g_um_reg   <= f_um_reg;
            g_uneg_reg <= f_uneg_reg;

            // stage h: penetration and contact test
            h_pmag_reg    <= h_pmag_next;
            h_pneg_reg    <= h_pneg_next;
            h_pen_reg     <= h_pneg_next ? 48'(-{14'd0, h_pmag_next}) : {14'd0, h_pmag_next};
            h_applied_reg <= !contact_mode_reg || h_pneg_next;
            h_um_reg      <= g_um_reg;
            h_uneg_reg    <= g_uneg_reg;

            // stage i: second factors of the force and stiffness products
            for (int i = 0; i < 3; i++) begin
                i_b_reg[i]   <= 64'(64'(h_pmag_reg) * 64'(h_um_reg[i]));
                i_neg_reg[i] <= !(h_pneg_reg ^ h_uneg_reg[i]);
            end
            for (int p = 0; p < 6; p++) begin
                i_b_reg[3+p]   <= 64'(h_um_reg[PAIR_ROW[p]]) * 64'(h_um_reg[PAIR_COL[p]]);
                i_neg_reg[3+p] <= h_uneg_reg[PAIR_ROW[p]] ^ h_uneg_reg[PAIR_COL[p]];
            end
            i_applied_reg <= h_applied_reg;
            i_pen_reg     <= h_pen_reg;

            // stages j, k: hold side data level with the multipliers
            j_neg_reg     <= i_neg_reg;
            j_applied_reg <= i_applied_reg;
            j_pen_reg     <= i_pen_reg;
            k_neg_reg     <= j_neg_reg;
            k_applied_reg <= j_applied_reg;
            k_pen_reg     <= j_pen_reg;
        end
    end

    for (genvar n = 0; n < 9; n++) begin : g_mul
        pcnk_mul64 u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (ka_reg),
            .b    (i_b_reg[n]),
            .prod (prod[n])
        );
    end

    // output stage: round, saturate, gate
    logic [479:0] m_tdata_next;
    always_comb begin
        m_tdata_next[47:0] = k_pen_reg;
        for (int i = 0; i < 3; i++) begin
            m_tdata_next[48 + 48*i +: 48] = (reaction_mode_reg || k_applied_reg)
                ? round_sat(prod[i], k_neg_reg[i], SHIFT_FORCE) : 48'd0;
        end
        for (int p = 0; p < 6; p++) begin
            m_tdata_next[192 + 48*p +: 48] = k_applied_reg
                ? round_sat(prod[3+p], k_neg_reg[3+p], SHIFT_STIFF) : 48'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg   <= m_tdata_next;
            m_applied_reg <= k_applied_reg;
        end
    end

    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_applied_reg;

    `PCNK_ASSERT_NORST(a_reset_empties, !aresetn |=> !m_tvalid, "output valid after reset")
    `PCNK_ASSERT(a_stiff_gated, m_tvalid && !m_tuser[0] |-> m_tdata[479:192] == '0,
                 "stiffness not zero when inactive")
    `PCNK_ASSERT(a_force_gated,
                 m_tvalid && !m_tuser[0] && !reaction_mode_reg |-> m_tdata[191:48] == '0,
                 "force not zero when inactive")
    `PCNK_ASSERT(a_contact_sign, m_tvalid && contact_mode_reg && !m_tuser[0] |-> !m_tdata[47],
                 "negative penetration left inactive")

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for penalty_contact_node_kernel_top: random and directed node beats,
// APB register phases, a bit-exact fixed-point predictor and an in-order result check.
// Depends on pcnk_pkg and the kernel RTL.
`timescale 1ns / 1ps

module tb_top;
    import pcnk_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic         applied;
        logic [479:0] data;
    } node_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;     // disp_x, disp_y, disp_z, norm_x, norm_y, norm_z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [479:0] m_tdata;          // penetration, force_x/y/z, stiff xx xy xz yy yz zz
    logic [0:0]   m_tuser;          // applied
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic [191:0] pending_nodes[$];
    node_result_t expected_results[$];
    logic [31:0]  coeff_k, area_a;
    logic         contact_on, reaction_on;
    logic         idling_on = 1'b1;
    int           mismatches = 0;
    int           results_seen = 0;
    int           hold_left = 0;
    bit           held = 1'b0;
    int           cycles = 0;

    penalty_contact_node_kernel_top dut (.*);

    always #5 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Round half away from zero at bit s, apply sign, clamp to 48 bits
    function automatic logic [47:0] scaled(logic [127:0] prod, logic neg, int s);
        logic [127:0] m;
        logic [127:0] lim;
        m = (prod + (128'd1 << (s - 1))) >> s;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (m > lim) m = lim;
        return neg ? 48'(-m[47:0]) : m[47:0];
    endfunction

    function automatic node_result_t predict_node(logic [191:0] nd);
        node_result_t res;
        logic signed [63:0] d[3], raw[3], u[3];
        logic signed [63:0] acc, pen;
        logic [63:0] mag[3], umag[3];
        logic [63:0] sum, r, q, ka, pmag;
        logic applied;
        logic [47:0] f;
        int ii[6], jj[6];
        ii = '{0, 0, 0, 1, 1, 2};
        jj = '{0, 1, 2, 1, 2, 2};
        sum = 0;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            if (i < 2 || DIMENSION == 3) begin
                d[i] = 64'($signed(nd[32*i +: 32]));
                raw[i] = 64'($signed(nd[96 + 32*i +: 32]));
            end else begin
                d[i] = 0;
                raw[i] = 0;
            end
            mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
            sum += mag[i] * mag[i];
        end
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            u[i] = 0;
            if (r != 0) begin
                q = ((mag[i] << 30) + (r >> 1)) / r;
                u[i] = raw[i] > 0 ? -$signed(q) : $signed(q);
            end
            umag[i] = u[i] < 0 ? -u[i] : u[i];
            acc += d[i] * u[i];
        end
        pmag = ((acc < 0 ? -acc : acc) + (64'd1 << 29)) >> 30;
        pen = acc < 0 ? -$signed(pmag) : $signed(pmag);
        applied = !contact_on || pen < 0;
        ka = 64'(coeff_k) * 64'(area_a);
        res.applied = applied;
        res.data = '0;
        res.data[47:0] = pen[47:0];
        for (int i = 0; i < 3; i++) begin
            f = scaled({64'd0, ka} * {64'd0, pmag * umag[i]}, (pen < 0) == (u[i] < 0), 62);
            res.data[48*(1+i) +: 48] = (reaction_on || applied) ? f : 48'd0;
        end
        for (int e = 0; e < 6; e++) begin
            f = scaled({64'd0, ka} * {64'd0, umag[ii[e]] * umag[jj[e]]},
                       (u[ii[e]] < 0) != (u[jj[e]] < 0), 76);
            res.data[48*(4+e) +: 48] = applied ? f : 48'd0;
        end
        return res;
    endfunction

    function automatic logic [191:0] node(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                         logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
        return {nz, ny, nx, dz, dy, dx};
    endfunction

    function automatic logic [31:0] modest();
        int v;
        v = int'($urandom_range(0, 2**21)) - 2**20;
        return 32'(v);
    endfunction

    function automatic logic [191:0] random_node();
        int kind;
        logic [31:0] c[6];
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 6; i++) c[i] = kind < 60 ? modest() : $urandom();
        if (kind >= 85 && kind < 95) begin
            // axis-aligned normal
            c[3] = 0;
            c[4] = 0;
            c[5] = 0;
            c[3 + $urandom_range(0, 2)] = modest();
        end else if (kind >= 95) begin
            c[3] = 0;
            c[4] = 0;
            c[5] = 0;
        end
        return node(c[0], c[1], c[2], c[3], c[4], c[5]);
    endfunction

    // Sender: advance to the next beat once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(), predict_node(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_nodes.size() > 0 && !(idling_on && $urandom_range(0, 99) < 7)) begin
                    s_tdata <= pending_nodes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each beat, stall at random, one long hold-off to back up the pipe
    always @(posedge aclk) begin
        node_result_t exp_r;
        string names[10];
        names = '{"penetration", "force_x", "force_y", "force_z", "stiff_xx",
                  "stiff_xy", "stiff_xz", "stiff_yy", "stiff_yz", "stiff_zz"};
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser[0] !== exp_r.applied) begin
                        $error("applied: expected %0b, got %0b", exp_r.applied, m_tuser[0]);
                        mismatches++;
                    end
                    for (int i = 0; i < 10; i++) begin
                        if (m_tdata[48*i +: 48] !== exp_r.data[48*i +: 48]) begin
                            $error("%s: expected %h, got %h", names[i],
                                   exp_r.data[48*i +: 48], m_tdata[48*i +: 48]);
                            mismatches++;
                        end
                    end
                end
            end
            if (!held && results_seen >= 520) begin
                held <= 1'b1;
                hold_left <= 400;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idling_on && $urandom_range(0, 99) < 7);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PENALTY_COEFF: coeff_k = value;
            REG_NODAL_AREA:    area_a = value;
            REG_CONTACT_MODE:  contact_on = value[0];
            default:           reaction_on = value[0];
        endcase
    endtask

    task automatic configure(logic [31:0] k, logic [31:0] a, logic [31:0] cm, logic [31:0] rm);
        reg_write(REG_PENALTY_COEFF, k);
        reg_write(REG_NODAL_AREA, a);
        reg_write(REG_CONTACT_MODE, cm);
        reg_write(REG_REACTION_MODE, rm);
    endtask

    // Drain: wait until every beat is out, then let the pipe settle
    task automatic drain();
        while (pending_nodes.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Append one node beat to the tail of the send queue
    task automatic queue_node(logic [191:0] nd);
        pending_nodes.insert(pending_nodes.size(), nd);
    endtask

    task automatic load_directed();
        queue_node(node(0, 0, 0, 0, 0, 0));
        queue_node(node(ONE, -ONE, 32'h7FFF_FFFF, 0, 0, 0));
        queue_node(node(ONE, 0, 0, ONE, 0, 0));
        queue_node(node(ONE, 0, 0, -ONE, 0, 0));
        queue_node(node(0, 0, 3 * ONE, 0, 0, 5 * ONE));
        queue_node(node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_node(node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_node(node(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_node(node(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
        queue_node(node(1, 0, 0, ONE, 2 * ONE, 3 * ONE));
        queue_node(node(-1, 1, 1, ONE, 2 * ONE, 3 * ONE));
        queue_node(node(-ONE, -ONE, 0, 1, 1, 1));
    endtask

    initial begin
        coeff_k = 0;
        area_a = 0;
        contact_on = 0;
        reaction_on = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        configure(ONE, ONE, 0, 0);
        load_directed();
        drain();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
        load_directed();
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
                1: configure(2 * ONE, ONE / 2, 1, 0);
                2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
                default: configure($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2**22),
                                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2**20),
                                   $urandom(), $urandom());
            endcase
            // no random gaps on either side for one whole phase
            idling_on = (phase != 4);
            repeat (205) queue_node(random_node());
            drain();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
